// ===== hdl/tmn_pkg.sv =====
// Shared types and constants for the thruster mixer and normalizer.
`default_nettype none

package tmn_pkg;

  localparam int COEF_W    = 16;
  localparam int SP_W      = 16;
  localparam int NUM_COEFS = 6;
  localparam int PROD_W    = COEF_W + SP_W;
  // Six products summed exactly need three more bits than one product.
  localparam int ACC_W     = PROD_W + 3;
  localparam int MAG_W     = ACC_W - 1;
  localparam int ACC_FRAC  = (COEF_W - 5) + (SP_W - 2);
  localparam int THR_W     = 16;
  localparam int QUO_W     = THR_W - 1;
  localparam int DIV_STEPS = 16;
  localparam int CHAN_W    = 4;
  localparam int SEL_W     = 3;

  localparam logic [MAG_W-1:0] ONE_ACC    = MAG_W'(1) << ACC_FRAC;
  localparam logic [SEL_W-1:0] COEF_LAST  = SEL_W'(NUM_COEFS - 1);
  localparam logic [QUO_W-1:0] THROTTLE_MAX = {QUO_W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DIV,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

`default_nettype wire

// ===== hdl/tmn_coef_mem.sv =====
// Coefficient memory with per-entry valid bits so that unwritten entries read as zero.
`default_nettype none

module tmn_coef_mem
  import tmn_pkg::*;
#(
  parameter int DEPTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [COEF_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [COEF_W-1:0] rd_data
);

  logic [COEF_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [COEF_W-1:0] rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hdl/tmn_mac.sv =====
// Shared multiply-accumulate unit that forms one thruster actuation and its magnitude.
`default_nettype none

module tmn_mac
  import tmn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_tag_t                 tag,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [SP_W-1:0]   sp,
  output logic                     res_valid,
  output logic                     res_neg,
  output logic [MAG_W-1:0]         res_mag
);

  logic signed [PROD_W-1:0] prod;
  mac_tag_t                 p_tag;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_base;
  logic                     a_done;

  assign acc_base = p_tag.first ? '0 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag     <= '0;
      a_done    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p_tag     <= tag;
      a_done    <= p_tag.valid && p_tag.last;
      res_valid <= a_done;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * sp;
    if (p_tag.valid) begin
      acc <= acc_base + ACC_W'(prod);
    end
    res_neg <= acc[ACC_W-1];
    res_mag <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
  end

endmodule

`default_nettype wire

// ===== hdl/tmn_div.sv =====
// Restoring divider giving a rounded, saturated Q0.15 magnitude, one quotient bit per cycle.
`default_nettype none

module tmn_div
  import tmn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  input  logic [MAG_W-1:0] dvs,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [MAG_W:0]         rem;
  logic [MAG_W:0]         rem_sh;
  logic [MAG_W-1:0]       dvs_q;
  logic [DIV_STEPS-1:0]   q;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   ge;
  logic [DIV_STEPS:0]     q_round;
  logic [DIV_STEPS-1:0]   q_half;

  // The remainder never exceeds the divisor, so its top bit is always clear before the shift.
  assign rem_sh = {rem[MAG_W-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, mag};
      dvs_q <= dvs;
      q     <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      q   <= {q[DIV_STEPS-2:0], ge};
    end
  end

  // Round half away from zero by dropping the extra quotient bit after adding one.
  assign q_round = {1'b0, q} + (DIV_STEPS + 1)'(1);
  assign q_half  = q_round[DIV_STEPS:1];
  assign quo     = (q_half > DIV_STEPS'(THROTTLE_MAX)) ? THROTTLE_MAX : q_half[QUO_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/thruster_mixer_normalizer_unit.sv =====
// Top level of the thruster mixer: request decode, sequencer, tables and output register.
//
// Input stream (s_*): a request with s_tuser = 0 loads one coefficient and the
// thruster's output channel; an out-of-range thruster or slot is ignored.
// A request with s_tuser = 1 carries six setpoints and produces NUM_UNITS throttle
// results on the output stream (m_*), in thruster order, m_tlast on the final one.
// An apply runs the multiply-accumulate pass, one coefficient per cycle
// through the single multiplier, and then divides thruster by thruster
// in the shared one-bit-per-cycle divider.
// s_tready is high only while the block is idle.
// Results leave through one output register; when the receiver stalls, the
// divider finishes the next thruster and then waits, and s_tready stays low
// until the last throttle has been loaded into that register.
// Reset clears the coefficient table to zero (through per-entry valid bits),
// sets channel entry i to i, and empties the output register.
`default_nettype none

module thruster_mixer_normalizer_unit
  import tmn_pkg::*;
#(
  parameter int NUM_UNITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // thruster_sel[2:0], coef_sel[5:3], coef_value[21:6], out_channel[25:22],
  // move_x[41:26], move_y[57:42], move_z[73:58], turn_x[89:74], turn_y[105:90],
  // turn_z[121:106], zero fill[127:122]
  input  logic [127:0] s_tdata,
  // action[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // channel[3:0], throttle[19:4], zero fill[23:20]
  output logic [23:0]  m_tdata,
  output logic         m_tlast
);

  localparam int ENTRIES = NUM_UNITS * NUM_COEFS;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int UNIT_W  = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam logic [UNIT_W-1:0] UNIT_LAST = UNIT_W'(NUM_UNITS - 1);

  state_t state, state_next;

  logic               accept;
  logic               is_apply;
  logic [SEL_W-1:0]   thruster_sel;
  logic [SEL_W-1:0]   coef_sel;
  logic [COEF_W-1:0]  coef_value;
  logic [CHAN_W-1:0]  out_channel;
  logic               load_ok;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;

  logic signed [SP_W-1:0] sp [NUM_COEFS];

  logic [CHAN_W-1:0]  chan_tab [NUM_UNITS];
  logic [MAG_W-1:0]   mags [NUM_UNITS];
  logic [NUM_UNITS-1:0] negs;

  logic               iss_on;
  logic [ADDR_W-1:0]  iss_addr;
  logic [SEL_W-1:0]   iss_k;
  mac_tag_t           rd_tag;
  logic [SEL_W-1:0]   rd_k;
  logic [COEF_W-1:0]  rd_data;

  logic               res_valid;
  logic               res_neg;
  logic [MAG_W-1:0]   res_mag;
  logic [UNIT_W-1:0]  res_unit;
  logic [MAG_W-1:0]   peak;
  logic               mac_done;
  logic [MAG_W-1:0]   dvs;

  logic [UNIT_W-1:0]  u;
  logic               last_u;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   quo;
  logic               out_free;
  logic               out_load;
  logic [THR_W-1:0]   thr;
  logic [CHAN_W-1:0]  out_chan;
  logic [THR_W-1:0]   out_thr;

  assign thruster_sel = s_tdata[2:0];
  assign coef_sel     = s_tdata[5:3];
  assign coef_value   = s_tdata[21:6];
  assign out_channel  = s_tdata[25:22];
  assign is_apply     = s_tuser[0];
  assign accept       = s_tvalid && s_tready;

  assign load_ok = (int'(thruster_sel) < NUM_UNITS) && (coef_sel <= COEF_LAST);
  assign wr_en   = accept && !is_apply && load_ok;
  assign wr_addr = ADDR_W'(int'(thruster_sel) * NUM_COEFS + int'(coef_sel));

  // State register and next-state logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && is_apply) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (mac_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_done && out_free) begin
          state_next = last_u ? S_IDLE : S_DIV;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE: s_tready  = 1'b1;
      S_MAC:  s_tready  = 1'b0;
      S_DIV:  div_start = 1'b1;
      S_WAIT: out_load  = div_done && out_free;
      default: s_tready = 1'b0;
    endcase
  end

  // Setpoints are held for the whole apply.
  always_ff @(posedge clk) begin
    if (accept && is_apply) begin
      sp[0] <= s_tdata[41:26];
      sp[1] <= s_tdata[57:42];
      sp[2] <= s_tdata[73:58];
      sp[3] <= s_tdata[89:74];
      sp[4] <= s_tdata[105:90];
      sp[5] <= s_tdata[121:106];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        chan_tab[i] <= CHAN_W'(i);
      end
    end else if (wr_en) begin
      chan_tab[UNIT_W'(thruster_sel)] <= out_channel;
    end
  end

  tmn_coef_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (coef_value),
    .rd_en   (iss_on),
    .rd_addr (iss_addr),
    .rd_data (rd_data)
  );

  // Address walk: one coefficient per cycle, thruster by thruster.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_on <= 1'b0;
      rd_tag <= '0;
    end else begin
      rd_tag.valid <= iss_on;
      rd_tag.first <= (iss_k == '0);
      rd_tag.last  <= (iss_k == COEF_LAST);
      if (accept && is_apply) begin
        iss_on <= 1'b1;
      end else if (iss_on && iss_addr == ADDR_W'(ENTRIES - 1)) begin
        iss_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k <= iss_k;
    if (accept && is_apply) begin
      iss_addr <= '0;
      iss_k    <= '0;
    end else if (iss_on) begin
      iss_addr <= iss_addr + ADDR_W'(1);
      iss_k    <= (iss_k == COEF_LAST) ? '0 : iss_k + SEL_W'(1);
    end
  end

  tmn_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .tag       (rd_tag),
    .coef      ($signed(rd_data)),
    .sp        (sp[rd_k]),
    .res_valid (res_valid),
    .res_neg   (res_neg),
    .res_mag   (res_mag)
  );

  // Collect magnitudes and track the peak as results leave the accumulator.
  always_ff @(posedge clk) begin
    if (accept && is_apply) begin
      res_unit <= '0;
      peak     <= '0;
    end else if (res_valid) begin
      mags[res_unit] <= res_mag;
      negs[res_unit] <= res_neg;
      res_unit       <= res_unit + UNIT_W'(1);
      if (res_mag > peak) begin
        peak <= res_mag;
      end
    end
  end

  assign mac_done = (state == S_MAC) && res_valid && (res_unit == UNIT_LAST);
  assign dvs      = (peak > ONE_ACC) ? peak : ONE_ACC;

  tmn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mags[u]),
    .dvs   (dvs),
    .done  (div_done),
    .quo   (quo)
  );

  assign last_u   = (u == UNIT_LAST);
  assign out_free = !m_tvalid || m_tready;
  assign thr      = negs[u] ? -{1'b0, quo} : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (accept && is_apply) begin
      u <= '0;
    end else if (out_load && !last_u) begin
      u <= u + UNIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan <= chan_tab[u];
      out_thr  <= thr;
      m_tlast  <= last_u;
    end
  end

  assign m_tdata = {4'b0000, out_thr, out_chan};

endmodule

`default_nettype wire
